// ===== hdl/tkn_pkg.sv =====
// Shared types, constants and the ordering function for the top-k nearest selector.
package tkn_pkg;

  localparam int DIST_W          = 32;
  localparam int IDX_W           = 16;
  localparam int RANK_W          = 4;
  localparam int NC_W            = 5;
  localparam int RESULT_CAP      = 16;
  localparam int MAX_NEIGHBORS_D = 16;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  // Register word select, taken from paddr[2].
  localparam logic REG_NEIGHBOR_COUNT = 1'b0;

  localparam logic [NC_W-1:0] NEIGHBOR_COUNT_RST = NC_W'(1);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    entry_t ent;
    logic   after;
  } link_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic live;
    logic ins;
  } cell_ctl_t;

  // True when stored entry a orders after candidate b (distance, then index).
  function automatic logic entry_after(entry_t a, entry_t b);
    logic res;
    if (a.distance != b.distance) res = a.distance > b.distance;
    else                          res = a.idx > b.idx;
    return res;
  endfunction

endpackage

// ===== hdl/streaming_top_k_nearest.sv =====
// Top level of the streaming top-k nearest selector: sorted cell chain plus result bank.
//
//  channel   dir  handshake           payload
//  in        in   in_valid/in_stall   candidate_distance, point_index, query_end
//  out       out  out_valid/out_stall neighbor_index, neighbor_distance, neighbor_rank, run_last
//  apb       in   psel/penable/pready neighbor_count at byte address 0
//
// One candidate per cycle; every cell compares and shifts in the same cycle.
// The query-end item also copies the store into the result bank, which gives
// one result per cycle, up to 16 per query. A query-end item waits in in_stall
// only while the previous run is still in the bank.
// Synchronous reset empties the store and bank and sets neighbor_count to 1.
// out_stall holds the bank; candidates that do not end a query keep flowing.
module streaming_top_k_nearest
  import tkn_pkg::*;
#(
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_D
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DIST_W-1:0] candidate_distance,
  input  logic [IDX_W-1:0]  point_index,
  input  logic              query_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  neighbor_index,
  output logic [DIST_W-1:0] neighbor_distance,
  output logic [RANK_W-1:0] neighbor_rank,
  output logic              run_last
);

  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

  logic [NC_W-1:0]  neighbor_count;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W-1:0] load_count;
  logic             accept;
  logic             append;
  logic             replace;
  logic             any_lt;
  logic             drain_busy;
  entry_t           cand;
  link_t            link  [MAX_NEIGHBORS];
  entry_t           nxt   [MAX_NEIGHBORS];
  logic             lt    [MAX_NEIGHBORS];
  cell_ctl_t        ctl   [MAX_NEIGHBORS];

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= NEIGHBOR_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_NEIGHBOR_COUNT) begin
      neighbor_count <= pwdata[NC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NEIGHBOR_COUNT) prdata = DATA_W'(neighbor_count);
  end

  // k clamped into 1..MAX_NEIGHBORS
  always_comb begin
    if (neighbor_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(neighbor_count) > MAX_NEIGHBORS) begin
      k_eff = CNT_W'(MAX_NEIGHBORS);
    end else begin
      k_eff = CNT_W'(neighbor_count);
    end
  end

  assign in_stall = in_valid && query_end && drain_busy;
  assign accept   = in_valid && !in_stall;

  assign cand.distance = candidate_distance;
  assign cand.idx      = point_index;

  // Store is sorted, so a candidate beats the worst entry iff it beats any held one.
  always_comb begin
    any_lt = 1'b0;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if (32'(kept_count) > i && lt[i]) any_lt = 1'b1;
    end
  end

  assign append      = kept_count < k_eff;
  assign replace     = !append && any_lt;
  assign limit       = append ? kept_count : kept_count - CNT_W'(1);
  assign count_after = append ? kept_count + CNT_W'(1) : kept_count;

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    link_t left;

    if (i == 0) begin : g_head
      assign left.ent   = cand;
      assign left.after = 1'b0;
    end else begin : g_body
      assign left = link[(i > 0) ? i - 1 : 0];
    end

    assign ctl[i].live = 32'(limit) > i;
    assign ctl[i].ins  = accept && (append || replace);

    tkn_cell u_cell (
      .clk      (clk),
      .cand     (cand),
      .left     (left),
      .ctl      (ctl[i]),
      .link     (link[i]),
      .ent_next (nxt[i]),
      .lt       (lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else if (accept) begin
      kept_count <= query_end ? '0 : count_after;
    end
  end

  always_comb begin
    if (32'(count_after) > RESULT_CAP) load_count = CNT_W'(RESULT_CAP);
    else                               load_count = count_after;
  end

  tkn_drain #(
    .DEPTH (MAX_NEIGHBORS),
    .CNT_W (CNT_W)
  ) u_drain (
    .clk               (clk),
    .rst               (rst),
    .load              (accept && query_end),
    .load_count        (load_count),
    .src               (nxt),
    .busy              (drain_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .neighbor_index    (neighbor_index),
    .neighbor_distance (neighbor_distance),
    .neighbor_rank     (neighbor_rank),
    .run_last          (run_last)
  );

endmodule

// ===== hdl/tkn_cell.sv =====
// One sorted-store cell: holds an entry and takes the candidate or its left neighbor's entry.
module tkn_cell
  import tkn_pkg::*;
(
  input  logic      clk,
  input  entry_t    cand,
  input  link_t     left,
  input  cell_ctl_t ctl,
  output link_t     link,
  output entry_t    ent_next,
  output logic      lt
);

  entry_t ent;
  logic   after;

  // Cells past the live prefix count as empty, so they always move when an insertion is made.
  assign after = !ctl.live || entry_after(ent, cand);
  assign lt    = cand.distance < ent.distance;

  always_comb begin
    ent_next = ent;
    if (ctl.ins && after) begin
      ent_next = left.after ? left.ent : cand;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  assign link.ent   = ent;
  assign link.after = after;

endmodule

// ===== hdl/tkn_drain.sv =====
// Result bank: snapshot of the store at query end, shifted out one entry per request.
module tkn_drain
  import tkn_pkg::*;
#(
  parameter int DEPTH = MAX_NEIGHBORS_D,
  parameter int CNT_W = $clog2(MAX_NEIGHBORS_D + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [CNT_W-1:0]  load_count,
  input  entry_t            src [DEPTH],
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  neighbor_index,
  output logic [DIST_W-1:0] neighbor_distance,
  output logic [RANK_W-1:0] neighbor_rank,
  output logic              run_last
);

  entry_t             bank [DEPTH];
  logic [CNT_W-1:0]   remain;
  logic [RANK_W-1:0]  rank;
  logic               shift;

  assign busy      = remain != '0;
  assign out_valid = busy;
  assign shift     = out_valid && !out_stall;

  for (genvar j = 0; j < DEPTH; j++) begin : g_bank
    always_ff @(posedge clk) begin
      if (load) begin
        bank[j] <= src[j];
      end else if (shift && j < DEPTH - 1) begin
        bank[j] <= bank[(j < DEPTH - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      rank   <= '0;
    end else if (load) begin
      remain <= load_count;
      rank   <= '0;
    end else if (shift) begin
      remain <= remain - CNT_W'(1);
      rank   <= rank + RANK_W'(1);
    end
  end

  assign neighbor_index    = bank[0].idx;
  assign neighbor_distance = bank[0].distance;
  assign neighbor_rank     = rank;
  assign run_last          = remain == CNT_W'(1);

endmodule

// ===== hdl/tkn_checker.sv =====
// Port-level checks for the top-k nearest selector, bound to the top level.
module tkn_port_checks
  import tkn_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              query_end,
  input logic              out_valid,
  input logic              out_stall,
  input logic [IDX_W-1:0]  neighbor_index,
  input logic [DIST_W-1:0] neighbor_distance,
  input logic [RANK_W-1:0] neighbor_rank,
  input logic              run_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(neighbor_index)
      && $stable(neighbor_distance) && $stable(neighbor_rank) && $stable(run_last))
    else $error("stalled result changed");

  // Within a run, ranks step by one.
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=>
      out_valid && neighbor_rank == RANK_W'($past(neighbor_rank) + 1'b1))
    else $error("rank did not advance within run");

  // Results come out in ascending distance.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> neighbor_distance >= $past(neighbor_distance))
    else $error("run not in ascending distance");

  // A new run starts at rank zero.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && run_last |=> !out_valid || neighbor_rank == '0)
    else $error("run did not start at rank zero");

  // Only a query-end request is ever held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid && query_end)
    else $error("input stalled without a query-end request");

endmodule

bind streaming_top_k_nearest tkn_port_checks u_tkn_port_checks (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .query_end         (query_end),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .neighbor_index    (neighbor_index),
  .neighbor_distance (neighbor_distance),
  .neighbor_rank     (neighbor_rank),
  .run_last          (run_last)
);

// ===== sim/tkn_checker.sv =====
// Checker for the top-k nearest selector: watches the channels, predicts neighbors, compares.
`timescale 1ns / 100ps

module tkn_checker
  import tkn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DIST_W-1:0] candidate_distance,
  input  logic [IDX_W-1:0]  point_index,
  input  logic              query_end,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [IDX_W-1:0]  neighbor_index,
  input  logic [DIST_W-1:0] neighbor_distance,
  input  logic [RANK_W-1:0] neighbor_rank,
  input  logic              run_last,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic [RANK_W-1:0] rank;
    logic              last;
  } neighbor_t;

  entry_t          held [MAX_NEIGHBORS_D];
  int              held_count = 0;
  logic [NC_W-1:0] k_reg = NEIGHBOR_COUNT_RST;
  neighbor_t       awaiting_neighbors [$];
  int              fail_tally = 0;

  // a sorts behind b: larger distance, or same distance and larger index
  function automatic bit sorts_behind(entry_t a, entry_t b);
    return (a.distance > b.distance) || (a.distance == b.distance && a.idx > b.idx);
  endfunction

  task automatic place_in_order(input int n, input entry_t cand);
    int j;
    j = n;
    while (j > 0 && sorts_behind(held[j-1], cand)) begin
      held[j] = held[j-1];
      j--;
    end
    held[j] = cand;
  endtask

  task automatic absorb_candidate(input entry_t cand, input logic closes_query);
    int        k;
    int        emit;
    neighbor_t nb;
    k = int'(k_reg);
    if (k == 0) k = 1;
    if (k > MAX_NEIGHBORS_D) k = MAX_NEIGHBORS_D;
    // store full (possibly over-full after k was lowered): only the worst may go
    if (held_count < k) begin
      place_in_order(held_count, cand);
      held_count++;
    end else if (held_count > 0 && cand.distance < held[held_count-1].distance) begin
      place_in_order(held_count - 1, cand);
    end
    if (closes_query) begin
      emit = (held_count > RESULT_CAP) ? RESULT_CAP : held_count;
      for (int r = 0; r < emit; r++) begin
        nb.idx      = held[r].idx;
        nb.distance = held[r].distance;
        nb.rank     = RANK_W'(r);
        nb.last     = (r == emit - 1);
        awaiting_neighbors = {awaiting_neighbors, nb};
      end
      held_count = 0;
    end
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin : watch
    entry_t    cand;
    neighbor_t want;
    if (rst) begin
      k_reg      = NEIGHBOR_COUNT_RST;
      held_count = 0;
      awaiting_neighbors.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_NEIGHBOR_COUNT)
        k_reg = pwdata[NC_W-1:0];
      if (in_valid && !in_stall) begin
        cand.distance = candidate_distance;
        cand.idx      = point_index;
        absorb_candidate(cand, query_end);
      end
      if (out_valid && !out_stall) begin
        if (awaiting_neighbors.size() == 0) begin
          $display({"%0t: unexpected neighbor: expected none, ",
                    "actual idx %0h distance %0h rank %0d last %b"},
                   $time, neighbor_index, neighbor_distance, neighbor_rank, run_last);
          fail_tally++;
        end else begin
          want = awaiting_neighbors.pop_front();
          report_field("neighbor_index", 32'(want.idx), 32'(neighbor_index));
          report_field("neighbor_distance", want.distance, neighbor_distance);
          report_field("neighbor_rank", 32'(want.rank), 32'(neighbor_rank));
          report_field("run_last", 32'(want.last), 32'(run_last));
        end
      end
    end
    fails   <= fail_tally;
    pending <= awaiting_neighbors.size();
  end

endmodule

// ===== sim/tb_streaming_top_k_nearest.sv =====
// Testbench top for the top-k nearest selector: stimulus, register writes, watchdog, verdict.
`timescale 1ns / 100ps

module tb_streaming_top_k_nearest
  import tkn_pkg::*;
();

  localparam int RANDOM_ITEMS  = 480;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 24;
  localparam int IDLE_LIMIT    = 2000;
  localparam logic [ADDR_W-1:0] NEIGHBOR_COUNT_ADDR = {REG_NEIGHBOR_COUNT, 2'b00};

  logic              clk;
  logic              rst                = 1'b1;
  logic              psel               = 1'b0;
  logic              penable            = 1'b0;
  logic              pwrite             = 1'b0;
  logic [ADDR_W-1:0] paddr              = '0;
  logic [DATA_W-1:0] pwdata             = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [DIST_W-1:0] candidate_distance = '0;
  logic [IDX_W-1:0]  point_index        = '0;
  logic              query_end          = 1'b0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [IDX_W-1:0]  neighbor_index;
  logic [DIST_W-1:0] neighbor_distance;
  logic [RANK_W-1:0] neighbor_rank;
  logic              run_last;
  int                fails;
  int                pending;

  int burst_left   = 0;
  int items_sent   = 0;
  int stall_hold   = 0;
  int idle_cycles  = 0;

  streaming_top_k_nearest u_top (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .candidate_distance (candidate_distance),
    .point_index        (point_index),
    .query_end          (query_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .neighbor_index     (neighbor_index),
    .neighbor_distance  (neighbor_distance),
    .neighbor_rank      (neighbor_rank),
    .run_last           (run_last)
  );

  tkn_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .candidate_distance (candidate_distance),
    .point_index        (point_index),
    .query_end          (query_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .neighbor_index     (neighbor_index),
    .neighbor_distance  (neighbor_distance),
    .neighbor_rank      (neighbor_rank),
    .run_last           (run_last),
    .fails              (fails),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: free-flowing stretches, short stalls, long stalls, random flicker
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(4, 30);
        end
        1: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(1, 3);
        end
        2: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(6, 14);
        end
        default: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_hold <= 0;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("streaming_top_k_nearest test failed");
        $finish;
      end
    end
  end

  function automatic logic [DIST_W-1:0] rand_distance();
    logic [DIST_W-1:0] d;
    case ($urandom_range(0, 7))
      0:       d = '0;
      1:       d = '1;
      2, 3:    d = DIST_W'($urandom_range(0, 7));   // dense ties
      default: d = $urandom;
    endcase
    return d;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [IDX_W-1:0] ix;
    case ($urandom_range(0, 3))
      0:       ix = IDX_W'($urandom_range(0, 3));
      1:       ix = '1;
      default: ix = IDX_W'($urandom);
    endcase
    return ix;
  endfunction

  function automatic logic [NC_W-1:0] pick_k();
    logic [NC_W-1:0] kv;
    case ($urandom_range(0, 7))
      0:       kv = NC_W'(1);
      1:       kv = NC_W'(MAX_NEIGHBORS_D);
      2:       kv = '0;
      3:       kv = NC_W'($urandom_range(MAX_NEIGHBORS_D + 1, 31));
      default: kv = NC_W'($urandom_range(1, MAX_NEIGHBORS_D));
    endcase
    return kv;
  endfunction

  // one request; bursts of back-to-back requests separated by random gaps
  task automatic send_candidate(input logic [DIST_W-1:0] d, input logic [IDX_W-1:0] ix,
                                input logic qe);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid           <= 1'b1;
    candidate_distance <= d;
    point_index        <= ix;
    query_end          <= qe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // drop valid, wait for every expected neighbor, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_neighbor_count(input logic [NC_W-1:0] kv);
    logic [DATA_W-1:0] word;
    word           = $urandom;
    word[NC_W-1:0] = kv;
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NEIGHBOR_COUNT_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int              k_eff;
    int              len;
    int              cut;
    int              n;
    int              target;
    logic [NC_W-1:0] kv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset value of k, extremes of the fields
    send_candidate('0, '0, 1'b1);
    set_neighbor_count(NC_W'(MAX_NEIGHBORS_D));
    send_candidate('1, '1, 1'b0);
    send_candidate('0, '1, 1'b0);
    send_candidate('0, '0, 1'b0);
    send_candidate(DIST_W'(5), IDX_W'(3), 1'b0);
    send_candidate(DIST_W'(5), IDX_W'(1), 1'b0);
    send_candidate(DIST_W'(5), IDX_W'(2), 1'b1);

    // full store: a tie with the worst distance never replaces it
    set_neighbor_count(NC_W'(2));
    send_candidate(DIST_W'(10), IDX_W'(7), 1'b0);
    send_candidate(DIST_W'(10), IDX_W'(9), 1'b0);
    send_candidate(DIST_W'(10), IDX_W'(1), 1'b0);
    send_candidate(DIST_W'(9), IDX_W'(100), 1'b0);
    send_candidate('1, '0, 1'b1);

    // k of zero acts as one
    set_neighbor_count('0);
    send_candidate(DIST_W'(7), IDX_W'(1), 1'b0);
    send_candidate(DIST_W'(3), IDX_W'(2), 1'b1);

    // k above the store size saturates
    set_neighbor_count('1);
    send_candidate(32'h8000_0000, 16'h8000, 1'b0);
    send_candidate(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    send_candidate(32'h0001_0000, 16'h0001, 1'b1);

    // k lowered below the held count in mid-query: nothing dropped
    set_neighbor_count(NC_W'(8));
    for (n = 0; n < 5; n++) send_candidate(DIST_W'(20 - n), IDX_W'(n), 1'b0);
    set_neighbor_count(NC_W'(2));
    send_candidate(DIST_W'(1), IDX_W'(50), 1'b0);
    send_candidate(DIST_W'(30), IDX_W'(51), 1'b1);

    target = RANDOM_ITEMS;
    while (items_sent < target) begin
      kv = pick_k();
      set_neighbor_count(kv);
      k_eff = (kv == 0) ? 1 : ((int'(kv) > MAX_NEIGHBORS_D) ? MAX_NEIGHBORS_D : int'(kv));
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 2 * k_eff + 3);
        cut = ($urandom_range(0, 7) == 0 && len > 2) ? len / 2 : 0;
        for (n = 0; n < len; n++) begin
          if (cut != 0 && n == cut) set_neighbor_count(NC_W'($urandom_range(1, k_eff)));
          send_candidate(rand_distance(), rand_index(), n == len - 1);
        end
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("streaming_top_k_nearest test passed");
    end else begin
      $display("streaming_top_k_nearest test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tkn_pkg.sv
hdl/tkn_cell.sv
hdl/tkn_drain.sv
hdl/streaming_top_k_nearest.sv
hdl/tkn_checker.sv
sim/tkn_checker.sv
sim/tb_streaming_top_k_nearest.sv
